// ===== design/ccs_pkg.sv =====
// Shared types, widths and status codes of the centered cosine similarity block.
package ccs_pkg;

	// Fixed datapath widths.
	localparam int CntW  = 13;
	localparam int LinW  = 36;
	localparam int SqW   = 52;
	localparam int MulW  = 57;
	localparam int ProdW = 2 * MulW;
	localparam int FracW = 28;
	localparam int RemW  = ProdW + FracW;
	localparam int QuoW  = 29;
	localparam int RootW = 15;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_VAR = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Finished sums of one vector pair, handed from front to back.
	typedef struct packed {
		logic                   too_long;
		logic [CntW-1:0]        n;
		logic signed [LinW-1:0] sa;
		logic signed [LinW-1:0] sb;
		logic signed [SqW-1:0]  sab;
		logic signed [SqW-1:0]  saa;
		logic signed [SqW-1:0]  sbb;
	} acc_t;

endpackage

// ===== design/ccs_front.sv =====
// Front part: takes element pairs and keeps the running count and sums.
module ccs_front import ccs_pkg::*; #(
	parameter int MAX_LEN   = 256,
	parameter int ELEM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] in_a,
	input  logic [15:0] in_b,
	input  logic        in_last,
	output logic        push,
	input  logic        push_ready,
	output acc_t        push_data
);

	localparam int ShAmt = 16 - ELEM_BITS;
	localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

	logic               valid_s1, last_s1, adv;
	logic signed [15:0] a_s1, b_s1, a_x, b_x;
	logic signed [31:0] ab_s1, aa_s1, bb_s1;
	logic [CntW-1:0]    cnt_q, cnt_n;
	logic signed [LinW-1:0] sa_q, sb_q, sa_n, sb_n;
	logic signed [SqW-1:0]  sab_q, saa_q, sbb_q, sab_n, saa_n, sbb_n;
	logic               add;

	// Take the low ELEM_BITS bits of each element as two's complement.
	assign a_x = $signed(in_a << ShAmt) >>> ShAmt;
	assign b_x = $signed(in_b << ShAmt) >>> ShAmt;

	// The stage moves on unless a finished vector waits for queue space.
	assign adv      = valid_s1 && (!last_s1 || push_ready);
	assign in_ready = !valid_s1 || adv;

	// Count saturates one past the limit; sums stop at the limit.
	always_comb begin
		cnt_n = cnt_q;
		add   = 1'b0;
		if (cnt_q <= MaxCnt) begin
			cnt_n = cnt_q + 1'b1;
			add   = cnt_n <= MaxCnt;
		end
		sa_n  = add ? sa_q + LinW'(a_s1) : sa_q;
		sb_n  = add ? sb_q + LinW'(b_s1) : sb_q;
		sab_n = add ? sab_q + SqW'(ab_s1) : sab_q;
		saa_n = add ? saa_q + SqW'(aa_s1) : saa_q;
		sbb_n = add ? sbb_q + SqW'(bb_s1) : sbb_q;
	end

	assign push = adv && last_s1;
	always_comb begin
		push_data.too_long = cnt_n > MaxCnt;
		push_data.n        = cnt_n;
		push_data.sa       = sa_n;
		push_data.sb       = sb_n;
		push_data.sab      = sab_n;
		push_data.saa      = saa_n;
		push_data.sbb      = sbb_n;
	end

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_s1    <= a_x;
			b_s1    <= b_x;
			ab_s1   <= a_x * b_x;
			aa_s1   <= a_x * a_x;
			bb_s1   <= b_x * b_x;
			last_s1 <= in_last;
		end
	end

	// Accumulators, cleared after the last pair of a vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			sab_q <= '0;
			saa_q <= '0;
			sbb_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q <= '0;
				sa_q  <= '0;
				sb_q  <= '0;
				sab_q <= '0;
				saa_q <= '0;
				sbb_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				sa_q  <= sa_n;
				sb_q  <= sb_n;
				sab_q <= sab_n;
				saa_q <= saa_n;
				sbb_q <= sbb_n;
			end
		end
	end

endmodule

// ===== design/ccs_queue.sv =====
// Two-entry queue of finished sums between the front and back parts.
module ccs_queue import ccs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	output logic wr_ready,
	input  acc_t wr_data,
	output logic rd_valid,
	input  logic rd,
	output acc_t rd_data
);

	acc_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && wr_ready) wp_q <= ~wp_q;
			if (rd && rd_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && wr_ready) - 2'(rd && rd_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (wr && wr_ready) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== design/ccs_back.sv =====
// Back part: centered terms, divide and root, one step a cycle unless output is held.
module ccs_back import ccs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  acc_t        q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_sim,
	output logic [1:0]  out_status
);

	typedef enum logic [2:0] {IDLE, LOAD, MUL, DIV, SQRT, DONE} state_t;

	state_t                  state_q;
	acc_t                    acc_q;
	logic [2:0]              step_q;
	logic signed [MulW-1:0]  t_q, num_q, va_q, vb_n;
	logic signed [MulW-1:0]  ma, mb;
	logic [MulW-1:0]         mpl_q, mag_a, mag_b;
	logic [ProdW-1:0]        sh_q, pacc_q;
	logic signed [ProdW-1:0] p;
	logic                    neg_q;
	logic [RemW-1:0]         rem_q, div_q;
	logic [QuoW-1:0]         quo_q;
	logic [4:0]              dcnt_q;
	logic [3:0]              bit_q;
	logic [RootW-1:0]        root_q, cand;
	logic [2*RootW-1:0]      cand_sq;
	logic [1:0]              code_q;
	logic [1:0]              stat_q;
	logic                    ov_q;
	logic [15:0]             sim_q;

	// Operand pair of each multiply step.
	always_comb begin
		case (step_q)
			3'd0: begin ma = MulW'($signed({1'b0, acc_q.n})); mb = MulW'(acc_q.sab); end
			3'd1: begin ma = MulW'(acc_q.sa); mb = MulW'(acc_q.sb); end
			3'd2: begin ma = MulW'($signed({1'b0, acc_q.n})); mb = MulW'(acc_q.saa); end
			3'd3: begin ma = MulW'(acc_q.sa); mb = MulW'(acc_q.sa); end
			3'd4: begin ma = MulW'($signed({1'b0, acc_q.n})); mb = MulW'(acc_q.sbb); end
			3'd5: begin ma = MulW'(acc_q.sb); mb = MulW'(acc_q.sb); end
			3'd6: begin ma = num_q; mb = num_q; end
			default: begin ma = va_q; mb = t_q; end
		endcase
	end

	assign mag_a   = ma[MulW-1] ? MulW'(-ma) : MulW'(ma);
	assign mag_b   = mb[MulW-1] ? MulW'(-mb) : MulW'(mb);
	assign p       = neg_q ? -$signed(pacc_q) : $signed(pacc_q);
	assign vb_n    = t_q - p[MulW-1:0];
	assign cand    = root_q | (RootW'(1) << bit_q);
	assign cand_sq = cand * cand;
	assign q_pop   = (state_q == IDLE) && q_valid;

	assign out_valid  = ov_q;
	assign out_sim    = sim_q;
	assign out_status = stat_q;

	// Sequencer with the shared shift-add multiplier, divider and root unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ov_q    <= 1'b0;
			step_q  <= 3'd0;
			code_q  <= ST_OK;
			stat_q  <= ST_OK;
			sim_q   <= '0;
		end else begin
			// The result register empties when taken, unless a new result replaces it.
			if (out_ready && state_q != DONE) ov_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (q_valid) begin
						acc_q  <= q_data;
						step_q <= 3'd0;
						root_q <= '0;
						num_q  <= '0;
						if (q_data.too_long) begin
							code_q  <= ST_TOO_LONG;
							state_q <= DONE;
						end else begin
							code_q  <= ST_OK;
							state_q <= LOAD;
						end
					end
				end
				LOAD: begin
					sh_q    <= ProdW'(mag_a);
					mpl_q   <= mag_b;
					neg_q   <= ma[MulW-1] ^ mb[MulW-1];
					pacc_q  <= '0;
					state_q <= MUL;
				end
				MUL: begin
					if (mpl_q == '0) begin
						step_q <= step_q + 3'd1;
						case (step_q)
							3'd1: begin
								num_q   <= t_q - p[MulW-1:0];
								state_q <= LOAD;
							end
							3'd3: begin
								va_q    <= t_q - p[MulW-1:0];
								state_q <= LOAD;
							end
							3'd5: begin
								t_q <= vb_n;
								if (va_q <= 0 || vb_n <= 0) begin
									code_q  <= ST_ZERO_VAR;
									state_q <= DONE;
								end else begin
									state_q <= LOAD;
								end
							end
							3'd6: begin
								rem_q   <= {pacc_q, {FracW{1'b0}}};
								state_q <= LOAD;
							end
							3'd7: begin
								div_q   <= {pacc_q, {FracW{1'b0}}};
								quo_q   <= '0;
								dcnt_q  <= 5'(QuoW);
								state_q <= DIV;
							end
							default: begin
								t_q     <= p[MulW-1:0];
								state_q <= LOAD;
							end
						endcase
					end else begin
						if (mpl_q[0]) pacc_q <= pacc_q + sh_q;
						sh_q  <= sh_q << 1;
						mpl_q <= mpl_q >> 1;
					end
				end
				DIV: begin
					// Restoring division, one quotient bit a cycle.
					if (rem_q >= div_q) rem_q <= rem_q - div_q;
					quo_q  <= {quo_q[QuoW-2:0], rem_q >= div_q};
					div_q  <= div_q >> 1;
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd1) begin
						bit_q   <= 4'(RootW - 1);
						state_q <= SQRT;
					end
				end
				SQRT: begin
					// Integer square root, one result bit a cycle.
					if (cand_sq <= (2*RootW)'(quo_q)) root_q <= cand;
					bit_q <= bit_q - 4'd1;
					if (bit_q == 4'd0) state_q <= DONE;
				end
				DONE: begin
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						sim_q   <= num_q[MulW-1] ? 16'(-{1'b0, root_q}) : 16'(root_q);
						stat_q  <= code_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== design/centered_cosine_similarity.sv =====
// Top level of the centered cosine similarity (correlation) block.
// Element pairs enter at one per cycle while the front part is not held by a full
// queue; the front part accumulates them, and on the request marked tlast it hands
// the finished sums through a two-entry queue to the back part. The back part takes
// the sums, forms its eight shift-add products in turn, divides, takes the square
// root and loads the result register, overlapped with the next vectors while the
// queue has room. The result is the correlation in Q2.14 with a status in tuser;
// similarity is zero when status is not ok.
module centered_cosine_similarity import ccs_pkg::*; #(
	parameter int MAX_LEN   = 256,
	parameter int ELEM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // elem_a [15:0], elem_b [31:16]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // similarity [15:0]
	output logic [1:0]  m_axis_tuser   // status [1:0]
);

	logic push, push_ready, q_valid, q_pop;
	acc_t push_data, q_data;

	// Accumulation front.
	ccs_front #(.MAX_LEN(MAX_LEN), .ELEM_BITS(ELEM_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_a(s_axis_tdata[15:0]), .in_b(s_axis_tdata[31:16]), .in_last(s_axis_tlast),
		.push, .push_ready, .push_data
	);

	// Queue of finished sums.
	ccs_queue u_queue (
		.clk, .arst_n,
		.wr(push), .wr_ready(push_ready), .wr_data(push_data),
		.rd_valid(q_valid), .rd(q_pop), .rd_data(q_data)
	);

	// Final arithmetic and output register.
	ccs_back u_back (
		.clk, .arst_n,
		.q_valid, .q_pop, .q_data,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_sim(m_axis_tdata), .out_status(m_axis_tuser)
	);

endmodule

// ===== tb/sv/tb_centered_cosine_similarity.sv =====
// Self-checking testbench for the centered cosine similarity block.
module tb_centered_cosine_similarity import ccs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxLen = 256;
	localparam int OneQ   = 16384;

	// Expected result of one vector pair.
	typedef struct {
		logic signed [15:0] similarity;
		logic [1:0]         status;
	} corr_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	centered_cosine_similarity #(.MAX_LEN(MaxLen), .ELEM_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Predictor state: running sums of the current vector pair.
	int unsigned      pair_cnt;
	longint           acc_a, acc_b, acc_ab, acc_aa, acc_bb;
	corr_result_t     pending_results[$];
	int               sender_idle_pct;
	int               receiver_stall_pct;
	int               hold_off_cycles;
	int               mismatch_count;
	int               result_count;
	int               request_count;
	int               vector_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected status and similarity: square of a 64-bit magnitude times a 64-bit factor pair, compared exactly.
	function automatic corr_result_t predict_close();
		corr_result_t r;
		longint n, num, va, vb;
		logic [255:0] rhs, lhs, prod, mag;
		int unsigned lo, hi, mid;
		r.similarity = '0;
		r.status = ST_OK;
		n = pair_cnt;
		if (pair_cnt > MaxLen) begin
			r.status = ST_TOO_LONG;
		end else begin
			num = n * acc_ab - acc_a * acc_b;
			va = n * acc_aa - acc_a * acc_a;
			vb = n * acc_bb - acc_b * acc_b;
			if (va <= 0 || vb <= 0) begin
				r.status = ST_ZERO_VAR;
			end else begin
				mag = 256'(num < 0 ? -num : num);
				rhs = mag * mag * 256'(OneQ) * 256'(OneQ);
				prod = 256'(va) * 256'(vb);
				lo = 0;
				hi = OneQ;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					lhs = 256'(mid) * 256'(mid) * prod;
					if (lhs <= rhs) lo = mid;
					else hi = mid - 1;
				end
				r.similarity = num < 0 ? -16'(lo) : 16'(lo);
			end
		end
		return r;
	endfunction

	// Fold one pair into the predictor and queue a result on the last pair.
	task automatic accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last);
		longint la, lb;
		la = a;
		lb = b;
		if (pair_cnt <= MaxLen) begin
			pair_cnt++;
			if (pair_cnt <= MaxLen) begin
				acc_a += la;
				acc_b += lb;
				acc_ab += la * lb;
				acc_aa += la * la;
				acc_bb += lb * lb;
			end
		end
		if (last) begin
			pending_results.insert(pending_results.size(), predict_close());
			pair_cnt = 0;
			acc_a = 0; acc_b = 0; acc_ab = 0; acc_aa = 0; acc_bb = 0;
			vector_count++;
		end
	endtask

	// Offer one request and hold it until the block takes it; valid drops only when idle.
	task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		accumulate_pair(a, b, last);
		request_count++;
		@(negedge clk);
	endtask

	// Send one vector pair of the given length with random, equal, opposite or small-range content.
	task automatic send_vector(input int len, input int mode);
		logic signed [15:0] a, b;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: begin
					a = 16'($urandom);
					b = 16'($urandom);
				end
				1: begin
					a = 16'($urandom);
					b = a;
				end
				2: begin
					a = 16'($urandom);
					b = -a;
				end
				default: begin
					a = 16'($urandom_range(7)) - 16'sd3;
					b = 16'($urandom_range(3)) - 16'sd1;
				end
			endcase
			send_pair(a, b, i == len - 1);
		end
	endtask

	// Stop offering and wait until every expected result has come.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Ready generation, with an optional long hold-off.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(receiver_stall_pct > 0 &&
				$urandom_range(99) < receiver_stall_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		corr_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result sim=%0d status=%0d",
						$signed(m_axis_tdata), m_axis_tuser);
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata !== e.similarity || m_axis_tuser !== e.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected sim=%0d status=%0d, got sim=%0d status=%0d",
							e.similarity, e.status, $signed(m_axis_tdata), m_axis_tuser);
				end
			end
		end
	end

	// Extremes, perfect and inverse correlation, zero variance, overlong vectors.
	task automatic test_directed();
		send_pair(16'sh7fff, 16'sh8000, 1'b0);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sh7fff, 16'sh7fff, 1'b0);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sd5, 16'sd9, 1'b1);
		send_pair(16'sd3, 16'sd1, 1'b0);
		send_pair(16'sd3, 16'sd2, 1'b1);
		send_pair(-16'sd1, -16'sd1, 1'b0);
		send_pair(16'sd0, 16'sd0, 1'b0);
		send_pair(16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd1, 16'sd4, 1'b0);
		send_pair(16'sd2, 16'sd1, 1'b0);
		send_pair(16'sd3, 16'sd7, 1'b1);
		send_vector(4, 1);
		send_vector(4, 2);
		wait_drained();
		send_vector(MaxLen, 1);
		send_vector(MaxLen + 1, 0);
		send_vector(MaxLen + 5, 3);
		wait_drained();
	endtask

	// Random vectors, mostly short, under one idling profile.
	task automatic test_random(input int sender_pct, input int receiver_pct, input int pairs);
		int sent;
		int len;
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
		sent = 0;
		while (sent < pairs) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(MaxLen + 3, 40)
				: $urandom_range(8, 1);
			send_vector(len, $urandom_range(3));
			sent += len;
		end
		wait_drained();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	// Hold ready low long enough to fill the block and stall the input.
	task automatic test_backpressure();
		hold_off_cycles = 3000;
		for (int i = 0; i < 12; i++) send_vector(3, 0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 0;
		mismatch_count = 0;
		result_count = 0;
		request_count = 0;
		vector_count = 0;
		pair_cnt = 0;
		acc_a = 0; acc_b = 0; acc_ab = 0; acc_aa = 0; acc_bb = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(0, 0, 300);
		test_random(86, 0, 270);
		test_random(0, 86, 270);
		test_random(12, 12, 270);
		test_backpressure();
		repeat (1200) @(negedge clk);
		$display("Sent %0d pairs in %0d vectors; checked %0d results, %0d mismatches.",
			request_count, vector_count, result_count, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS centered_cosine_similarity");
		else
			$display("FAIL centered_cosine_similarity");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("FAIL centered_cosine_similarity");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ccs_pkg.sv
design/ccs_front.sv
design/ccs_queue.sv
design/ccs_back.sv
design/centered_cosine_similarity.sv
tb/sv/tb_centered_cosine_similarity.sv
